// ----- hdl/b64_pkg.sv -----
// Shared types, constants and the sextet-to-character mapping for the Base64 encoder.
`timescale 1ns / 1ps
package b64_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CharW  = 7;
    localparam int unsigned Sextet = 6;
    localparam int unsigned Chars  = 4;
    localparam int unsigned QueueDepth = 2;

    localparam logic [CharW-1:0] PadChar = 7'h3d;
    localparam logic [CharW-1:0] UpperA  = 7'h41;
    localparam logic [CharW-1:0] LowerA  = 7'h61;
    localparam logic [CharW-1:0] Digit0  = 7'h30;
    localparam logic [CharW-1:0] PlusCh  = 7'h2b;
    localparam logic [CharW-1:0] SlashCh = 7'h2f;

    localparam logic [ByteW-1:0] MaskHi6 = 8'hfc;
    localparam logic [ByteW-1:0] MaskLo2 = 8'h03;
    localparam logic [ByteW-1:0] MaskHi4 = 8'hf0;
    localparam logic [ByteW-1:0] MaskLo4 = 8'h0f;
    localparam logic [ByteW-1:0] MaskHi2 = 8'hc0;
    localparam logic [ByteW-1:0] MaskLo6 = 8'h3f;

    typedef struct packed {
        logic [Chars-1:0][CharW-1:0] chars;
        logic                        fin;
    } group_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_wr_t;

    typedef struct packed {
        logic pop;
        logic valid;
    } q_rd_t;

    function automatic logic [CharW-1:0] sextet_char(input logic [Sextet-1:0] s);
        logic [CharW-1:0] sx;
        sx = {1'b0, s};
        priority if (s < 6'd26) begin
            sextet_char = UpperA + sx;
        end else if (s < 6'd52) begin
            sextet_char = LowerA + sx - 7'd26;
        end else if (s < 6'd62) begin
            sextet_char = Digit0 + sx - 7'd52;
        end else if (s == 6'd62) begin
            sextet_char = PlusCh;
        end else begin
            sextet_char = SlashCh;
        end
    endfunction

endpackage

// ----- hdl/b64_front.sv -----
// Front end: holds pending bytes and turns each completed group into four characters.
`timescale 1ns / 1ps
module b64_front
    import b64_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ByteW-1:0] s_data_byte,
    input  logic             s_final_byte,
    output q_wr_t            q_wr,
    input  logic             q_full,
    output group_t           q_group
);

    logic [ByteW-1:0] first_reg, first_next;
    logic [ByteW-1:0] second_reg, second_next;
    logic [1:0]       count_reg, count_next;

    logic [1:0]       cnt;
    logic             fire;
    logic             emit;
    logic [ByteW-1:0] x0, x1, x2;
    logic [Chars-1:0][CharW-1:0] ch;

    assign s_ready = !q_full;
    assign fire    = s_valid && s_ready;
    assign cnt     = (count_reg == 2'd3) ? 2'd2 : count_reg;
    assign emit    = s_final_byte || (cnt == 2'd2);

    always_comb begin
        unique case (cnt)
            2'd0: begin
                x0 = s_data_byte; x1 = '0;          x2 = '0;
            end
            2'd1: begin
                x0 = first_reg;   x1 = s_data_byte; x2 = '0;
            end
            default: begin
                x0 = first_reg;   x1 = second_reg;  x2 = s_data_byte;
            end
        endcase
    end

    always_comb begin
        ch[0] = sextet_char(Sextet'((x0 & MaskHi6) >> 2));
        ch[1] = sextet_char(Sextet'({x0 & MaskLo2, 4'b0} | ((x1 & MaskHi4) >> 4)));
        ch[2] = sextet_char(Sextet'({x1 & MaskLo4, 2'b0} | ((x2 & MaskHi2) >> 6)));
        ch[3] = sextet_char(Sextet'(x2 & MaskLo6));
        q_group.fin   = s_final_byte;
        q_group.chars = ch;
        if (cnt == 2'd0) begin
            q_group.chars[2] = PadChar;
        end
        if (cnt != 2'd2) begin
            q_group.chars[3] = PadChar;
        end
    end

    assign q_wr.push = fire && emit;
    assign q_wr.full = q_full;

    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        if (fire) begin
            if (emit) begin
                first_next  = '0;
                second_next = '0;
                count_next  = 2'd0;
            end else if (cnt == 2'd0) begin
                first_next = s_data_byte;
                count_next = 2'd1;
            end else begin
                second_next = s_data_byte;
                count_next  = 2'd2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= '0;
            count_reg  <= 2'd0;
        end else begin
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/b64_queue.sv -----
// Short group queue between the front and back ends.
`timescale 1ns / 1ps
module b64_queue
    import b64_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  group_t wr_group,
    output logic   full,
    input  logic   pop,
    output logic   valid,
    output group_t rd_group
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    group_t            slot_reg [DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = (count_reg == CntW'(DEPTH));
    assign valid    = (count_reg != '0);
    assign rd_group = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        bump = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= wr_group;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/b64_back.sv -----
// Back end: sends the four characters of each queued group, one per request.
`timescale 1ns / 1ps
module b64_back
    import b64_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  q_rd_t            q_rd_in,
    output logic             q_pop,
    input  group_t           q_group,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CharW-1:0] m_out_char,
    output logic             m_group_end,
    output logic             m_message_end
);

    group_t     cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       last;
    logic       load;

    assign last  = (idx_reg == 2'd3);
    assign load  = !busy_reg || (m_ready && last);
    assign q_pop = load && q_rd_in.valid;

    assign m_valid       = busy_reg;
    assign m_out_char    = cur_reg.chars[idx_reg];
    assign m_group_end   = last;
    assign m_message_end = last && cur_reg.fin;

    always_comb begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load) begin
            cur_next  = q_group;
            idx_next  = 2'd0;
            busy_next = q_rd_in.valid;
        end else if (m_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (!aresetn) begin
            idx_reg  <= 2'd0;
            busy_reg <= 1'b0;
        end else begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ----- hdl/base64_encoder.sv -----
// Streaming Base64 encoder top level: front end, group queue and character back end.
//
// Input channel (s_): one plain byte per request, s_final_byte on the last byte
// of a message. Output channel (m_): one ASCII character per request; m_group_end
// marks the fourth character of a group, m_message_end the last of a message.
// Every third byte, or a flagged final byte, forms a group of four characters;
// a partial final group is zero-filled and padded with '='.
// m_valid rises once the group of a group-closing byte has been written into the
// queue and then loaded from the queue into the back end's character register.
// Throughput: one byte per cycle is taken while the group queue has room;
// output runs at one character per cycle while m_ready is high, four per group,
// so sustained input is limited by the single-character output port.
// The queue holds QUEUE_DEPTH groups besides the one in the back end.
// Reset clears held bytes, the count, the queue and the output valid.
// When the receiver stalls, the current character holds; bytes are still
// taken until the queue fills, then s_ready drops.
`timescale 1ns / 1ps
module base64_encoder
    import b64_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [ByteW-1:0] s_data_byte,
    input  logic             s_final_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CharW-1:0] m_out_char,
    output logic             m_group_end,
    output logic             m_message_end
);

    q_wr_t  q_wr;
    q_rd_t  q_rd;
    group_t wr_group;
    group_t rd_group;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign q_rd.pop   = q_pop;
    assign q_rd.valid = q_valid;

    b64_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .q_wr         (q_wr),
        .q_full       (q_full),
        .q_group      (wr_group)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_wr.push),
        .wr_group (wr_group),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .rd_group (rd_group)
    );

    b64_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_rd_in       (q_rd),
        .q_pop         (q_pop),
        .q_group       (rd_group),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_group_end   (m_group_end),
        .m_message_end (m_message_end)
    );

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push |-> !q_wr.full)
        else $error("group pushed into a full queue");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd.pop |-> q_rd.valid)
        else $error("group popped from an empty queue");

    a_msg_on_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_end) |-> m_group_end)
        else $error("message end away from a group end");

    a_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_group_end && q_valid) |=> m_valid)
        else $error("back end idled with a group waiting");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the streaming Base64 encoder: directed table, then random messages.
`timescale 1ns / 1ps
module tb;
    import b64_pkg::*;

    localparam int unsigned CycleLimit  = 500000;
    localparam int unsigned HoldCycles  = 300;
    localparam int unsigned DrainCycles = 16;
    localparam logic [8*64-1:0] Alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [31:0] NoTyped = '0;

    typedef struct packed {
        logic [CharW-1:0] ch;
        logic             grp;
        logic             msg;
    } enc_char_t;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             fin;
        logic [31:0]      typed;
    } plain_row_t;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_valid       = 1'b0;
    logic             s_ready;
    logic [ByteW-1:0] s_data_byte   = '0;
    logic             s_final_byte  = 1'b0;
    logic             m_valid;
    logic             m_ready       = 1'b0;
    logic [CharW-1:0] m_out_char;
    logic             m_group_end;
    logic             m_message_end;
    logic [31:0]      row_typed     = NoTyped;

    logic [ByteW-1:0] held_a = '0;
    logic [ByteW-1:0] held_b = '0;
    logic [1:0]       held_n = '0;

    enc_char_t   pending_chars[$];
    plain_row_t  plain_rows[$];
    int unsigned errors     = 0;
    int unsigned cycles     = 0;
    int unsigned items_sent = 0;
    bit          tx_gaps    = 1'b0;
    bit          rx_stalls  = 1'b0;
    bit          hold_req   = 1'b0;

    base64_encoder i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_final_byte (s_final_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_group_end  (m_group_end),
        .m_message_end(m_message_end)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ByteW-1:0] rand_byte();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hff;
        end
        return ByteW'($urandom_range(0, 255));
    endfunction

    task automatic encode_byte(input logic [ByteW-1:0] data, input logic fin,
                               input logic [31:0] typed);
        logic [ByteW-1:0] x0;
        logic [ByteW-1:0] x1;
        logic [ByteW-1:0] x2;
        logic [5:0]       sx [4];
        logic [1:0]       n;
        enc_char_t        c;
        n = (held_n > 2'd2) ? 2'd2 : held_n;
        if (!fin && n < 2'd2) begin
            if (n == 2'd0) begin
                held_a = data;
            end else begin
                held_b = data;
            end
            held_n = n + 2'd1;
        end else begin
            x0 = (n == 2'd0) ? data : held_a;
            x1 = (n == 2'd0) ? '0 : (n == 2'd1) ? data : held_b;
            x2 = (n == 2'd2) ? data : '0;
            sx[0] = x0[7:2];
            sx[1] = {x0[1:0], x1[7:4]};
            sx[2] = {x1[3:0], x2[7:6]};
            sx[3] = x2[5:0];
            for (int i = 0; i < 4; i++) begin
                if (typed != NoTyped) begin
                    c.ch = typed[30-8*i -: 7];
                end else if (i <= int'(n) + 1) begin
                    c.ch = Alphabet[8*(63-int'(sx[i])) +: 7];
                end else begin
                    c.ch = PadChar;
                end
                c.grp = (i == 3);
                c.msg = (i == 3) && fin;
                pending_chars = {pending_chars, c};
            end
            held_a = '0;
            held_b = '0;
            held_n = '0;
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        enc_char_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                encode_byte(s_data_byte, s_final_byte, row_typed);
            end
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    $display("%0t: unexpected character, expected none, got %h", $time,
                             m_out_char);
                    errors++;
                end else begin
                    want = pending_chars.pop_front();
                    if (m_out_char !== want.ch) begin
                        $display("%0t: out_char expected %h, got %h", $time, want.ch,
                                 m_out_char);
                        errors++;
                    end
                    if (m_group_end !== want.grp) begin
                        $display("%0t: group_end expected %b, got %b", $time, want.grp,
                                 m_group_end);
                        errors++;
                    end
                    if (m_message_end !== want.msg) begin
                        $display("%0t: message_end expected %b, got %b", $time, want.msg,
                                 m_message_end);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin : drive_ready
        bit          hold_spent;
        int unsigned stall;
        hold_spent = 1'b0;
        forever begin
            @(negedge aclk);
            stall = rx_stalls ? idle_len() : 0;
            if (hold_req && !hold_spent) begin
                m_ready <= 1'b0;
                repeat (HoldCycles) @(negedge aclk);
                hold_spent = 1'b1;
                m_ready <= 1'b1;
            end else if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic add_row(input logic [ByteW-1:0] data, input logic fin,
                           input logic [31:0] typed);
        plain_row_t row;
        row.data  = data;
        row.fin   = fin;
        row.typed = typed;
        plain_rows = {plain_rows, row};
    endtask

    task automatic send_byte(input logic [ByteW-1:0] data, input logic fin,
                             input logic [31:0] typed);
        int unsigned gap;
        gap = tx_gaps ? idle_len() : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= data;
        s_final_byte <= fin;
        row_typed    <= typed;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_messages(input int unsigned target);
        int unsigned len;
        int unsigned r;
        while (items_sent < target) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                len = $urandom_range(1, 3);
            end else if (r < 9) begin
                len = $urandom_range(4, 9);
            end else begin
                len = $urandom_range(10, 30);
            end
            for (int j = 0; j < len; j++) begin
                send_byte(rand_byte(), j == len - 1, NoTyped);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    initial begin
        add_row(8'h00, 1'b1, "AA==");
        add_row(8'hff, 1'b1, "/w==");
        add_row(8'h00, 1'b0, NoTyped);
        add_row(8'h00, 1'b1, "AAA=");
        add_row(8'hff, 1'b0, NoTyped);
        add_row(8'hff, 1'b1, "//8=");
        add_row(8'hff, 1'b0, NoTyped);
        add_row(8'hff, 1'b0, NoTyped);
        add_row(8'hff, 1'b0, "////");
        add_row(8'h00, 1'b0, NoTyped);
        add_row(8'h00, 1'b0, NoTyped);
        add_row(8'h00, 1'b1, "AAAA");
        add_row(8'h4d, 1'b0, NoTyped);
        add_row(8'h61, 1'b0, NoTyped);
        add_row(8'h6e, 1'b1, "TWFu");
        add_row(8'h4d, 1'b0, NoTyped);
        add_row(8'h61, 1'b1, "TWE=");
        add_row(8'h4d, 1'b1, "TQ==");
        add_row(8'hfb, 1'b0, NoTyped);
        add_row(8'hef, 1'b0, NoTyped);
        add_row(8'hbe, 1'b0, "++++");
        add_row(8'h5a, 1'b0, NoTyped);
        add_row(8'hc3, 1'b1, NoTyped);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plain_rows[i]) begin
            send_byte(plain_rows[i].data, plain_rows[i].fin, plain_rows[i].typed);
        end

        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_messages(220);

        // hold the sender until every request has been answered
        s_valid <= 1'b0;
        wait_drained();
        @(negedge aclk);

        // keep offering bytes while the receiver holds off
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        send_messages(290);

        tx_gaps = 1'b1;
        send_messages(430);

        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        send_messages(520);

        s_valid <= 1'b0;
        wait_drained();
        repeat (DrainCycles) @(posedge aclk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
